[rtl/gcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and constants of the gripper command sequencer: event and
// command codes, the transaction payloads and the configuration bundle.
// ----------------------------------------------------------------------------
package gcs_pkg;

  // event codes carried in the operation field
  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_OPEN      = 3'd1,
    OP_CLOSE     = 3'd2,
    OP_GRIP      = 3'd3,
    OP_STOP      = 3'd4,
    OP_ESTOP     = 3'd5,
    OP_KEEPALIVE = 3'd6,
    OP_TICK      = 3'd7
  } op_e;

  // servo command codes
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_HOLD   = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_OPEN_POSITION   = 3'd0,
    CFG_CLOSED_POSITION = 3'd1,
    CFG_TORQUE_LOW      = 3'd2,
    CFG_TORQUE_HIGH     = 3'd3,
    CFG_SERVO_SPEED     = 3'd4,
    CFG_KEEPALIVE_LIMIT = 3'd5
  } cfg_idx_e;

  // posture codes
  localparam logic [2:0] GRIP_OPEN  = 3'd0;
  localparam logic [2:0] GRIP_PINCH = 3'd1;
  localparam logic [2:0] GRIP_POINT = 3'd3;

  localparam logic [31:0] POLL_INTERVAL_MS = 32'd50;
  localparam logic [11:0] CLOSED_BACKOFF   = 12'd200;
  localparam int unsigned LOAD_W           = 10;
  localparam logic [8:0]  FORCE_FULL       = 9'd256;

  // configuration reset values
  localparam logic [11:0] RST_OPEN_POSITION   = 12'd0;
  localparam logic [11:0] RST_CLOSED_POSITION = 12'd4095;
  localparam logic [9:0]  RST_TORQUE_LOW      = 10'd100;
  localparam logic [9:0]  RST_TORQUE_HIGH     = 10'd1000;
  localparam logic [15:0] RST_SERVO_SPEED     = 16'd0;
  localparam logic [31:0] RST_KEEPALIVE_LIMIT = 32'd1000;

  // output buffer
  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_AW    = 2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        now_ms;
    logic signed [15:0] force_q8;
    logic [2:0]         grip_kind;
    logic               preview;
    logic               read_ok;
    logic [11:0]        read_position;
    logic [15:0]        read_load;
  } item_t;

  typedef struct packed {
    logic [1:0]        command_kind;
    logic [11:0]       goal_position;
    logic [9:0]        torque_limit;
    logic              estop_latched;
    logic              is_closing;
    logic [8:0]        force_level;
    logic [2:0]        posture;
    logic              servo_healthy;
    logic [11:0]       polled_position;
    logic [LOAD_W-1:0] polled_load;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [11:0] open_position;
    logic [11:0] closed_position;
    logic [9:0]  torque_low;
    logic [9:0]  torque_high;
    logic [15:0] servo_speed;
    logic [31:0] keepalive_limit_ms;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/gcs_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/gcs_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_core
// Gripper state and single-pass event decode: updates the state registers
// and forms up to two result transactions per event.
// ----------------------------------------------------------------------------
module gcs_core import gcs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  input  wire cfg_t    cfg_i,
  output result_t      res0_o,
  output result_t      res1_o,
  output logic         two_o
);

  logic              est_q, est_d;
  logic              clos_q, clos_d;
  logic [8:0]        force_q, force_d;
  logic [2:0]        post_q, post_d;
  logic              hlth_q, hlth_d;
  logic [11:0]       pos_q, pos_d;
  logic [LOAD_W-1:0] load_q, load_d;
  logic [31:0]       ka_q, ka_d;
  logic [31:0]       poll_q, poll_d;

  logic [1:0]         kind0;
  logic [11:0]        goal0;
  logic [9:0]         torq0;
  logic               loss_hold;
  logic [8:0]         force_cl;
  logic signed [10:0] span;
  logic signed [20:0] prod;
  logic signed [20:0] prod_rnd;
  logic signed [20:0] part;
  logic [9:0]         close_torq;
  logic [12:0]        pos_sum;
  logic [11:0]        grip_goal;
  logic [31:0]        poll_gap;
  logic [31:0]        ka_gap;
  logic               poll_due;
  logic               ka_loss;

  // close force clamp and torque interpolation, truncated toward zero
  always_comb begin
    if (item_i.force_q8[15]) begin
      force_cl = '0;
    end else if (item_i.force_q8 > $signed({7'd0, FORCE_FULL})) begin
      force_cl = FORCE_FULL;
    end else begin
      force_cl = item_i.force_q8[8:0];
    end
    span       = $signed({1'b0, cfg_i.torque_high}) - $signed({1'b0, cfg_i.torque_low});
    prod       = span * $signed({1'b0, force_cl});
    prod_rnd   = prod[20] ? prod + 21'sd255 : prod;
    part       = prod_rnd >>> 8;
    close_torq = cfg_i.torque_low + part[9:0];
  end

  // grip target position
  always_comb begin
    pos_sum = {1'b0, cfg_i.open_position} + {1'b0, cfg_i.closed_position};
    if (item_i.grip_kind inside {[GRIP_PINCH:GRIP_POINT]}) begin
      grip_goal = pos_sum[12:1];
    end else if (cfg_i.closed_position > CLOSED_BACKOFF) begin
      grip_goal = cfg_i.closed_position - CLOSED_BACKOFF;
    end else begin
      grip_goal = '0;
    end
  end

  // tick throttle and keepalive watchdog
  always_comb begin
    poll_gap = item_i.now_ms - poll_q;
    ka_gap   = item_i.now_ms - ka_q;
    poll_due = (poll_gap >= POLL_INTERVAL_MS);
    ka_loss  = (ka_q != '0) && (ka_gap > cfg_i.keepalive_limit_ms) && !est_q && clos_q;
  end

  // event decode
  always_comb begin
    est_d     = est_q;
    clos_d    = clos_q;
    force_d   = force_q;
    post_d    = post_q;
    hlth_d    = hlth_q;
    pos_d     = pos_q;
    load_d    = load_q;
    ka_d      = ka_q;
    poll_d    = poll_q;
    kind0     = CMD_STATUS;
    goal0     = '0;
    torq0     = '0;
    two_o     = 1'b0;
    loss_hold = 1'b0;
    if (fire_i) begin
      case (item_i.operation)
        OP_INIT: begin
          hlth_d = item_i.read_ok;
          kind0  = CMD_MOVE;
          goal0  = cfg_i.open_position;
          torq0  = cfg_i.torque_low;
        end
        OP_OPEN: begin
          if (!est_q) begin
            clos_d  = 1'b0;
            force_d = '0;
            post_d  = GRIP_OPEN;
            kind0   = CMD_MOVE;
            goal0   = cfg_i.open_position;
            torq0   = cfg_i.torque_high;
          end
        end
        OP_CLOSE: begin
          if (!est_q) begin
            force_d = force_cl;
            clos_d  = 1'b1;
            kind0   = CMD_MOVE;
            goal0   = cfg_i.closed_position;
            torq0   = close_torq;
          end
        end
        OP_GRIP: begin
          if (!est_q) begin
            post_d = item_i.grip_kind;
            kind0  = CMD_MOVE;
            if (item_i.grip_kind == GRIP_OPEN) begin
              clos_d  = 1'b0;
              force_d = '0;
              goal0   = cfg_i.open_position;
              torq0   = cfg_i.torque_high;
            end else begin
              clos_d = !item_i.preview;
              goal0  = grip_goal;
              torq0  = item_i.preview ? cfg_i.torque_low : (cfg_i.torque_high >> 1);
            end
          end
        end
        OP_STOP: begin
          clos_d = 1'b0;
          if (item_i.read_ok) begin
            kind0 = CMD_HOLD;
            goal0 = item_i.read_position;
          end
        end
        OP_ESTOP: begin
          est_d  = 1'b1;
          clos_d = 1'b0;
          kind0  = CMD_MOVE;
          goal0  = cfg_i.open_position;
          torq0  = cfg_i.torque_high;
        end
        OP_KEEPALIVE: begin
          ka_d = item_i.now_ms;
        end
        OP_TICK: begin
          if (poll_due) begin
            poll_d = item_i.now_ms;
            hlth_d = item_i.read_ok;
            if (item_i.read_ok) begin
              pos_d  = item_i.read_position;
              load_d = item_i.read_load[LOAD_W-1:0];
            end
            // watchdog release: optional hold, then the open move
            if (ka_loss) begin
              clos_d  = 1'b0;
              force_d = '0;
              post_d  = GRIP_OPEN;
              ka_d    = '0;
              if (item_i.read_ok) begin
                two_o     = 1'b1;
                loss_hold = 1'b1;
                kind0     = CMD_HOLD;
                goal0     = item_i.read_position;
              end else begin
                kind0 = CMD_MOVE;
                goal0 = cfg_i.open_position;
                torq0 = cfg_i.torque_high;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result transactions
  always_comb begin
    res0_o.command_kind    = kind0;
    res0_o.goal_position   = goal0;
    res0_o.torque_limit    = torq0;
    res0_o.estop_latched   = est_d;
    res0_o.is_closing      = clos_d;
    res0_o.force_level     = loss_hold ? force_q : force_d;
    res0_o.posture         = loss_hold ? post_q : post_d;
    res0_o.servo_healthy   = hlth_d;
    res0_o.polled_position = pos_d;
    res0_o.polled_load     = load_d;
    res0_o.last            = !two_o;

    res1_o.command_kind    = CMD_MOVE;
    res1_o.goal_position   = cfg_i.open_position;
    res1_o.torque_limit    = cfg_i.torque_high;
    res1_o.estop_latched   = est_d;
    res1_o.is_closing      = clos_d;
    res1_o.force_level     = force_d;
    res1_o.posture         = post_d;
    res1_o.servo_healthy   = hlth_d;
    res1_o.polled_position = pos_d;
    res1_o.polled_load     = load_d;
    res1_o.last            = 1'b1;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q   <= 1'b0;
      clos_q  <= 1'b0;
      force_q <= '0;
      post_q  <= GRIP_OPEN;
      hlth_q  <= 1'b0;
      pos_q   <= '0;
      load_q  <= '0;
      ka_q    <= '0;
      poll_q  <= '0;
    end else begin
      est_q   <= est_d;
      clos_q  <= clos_d;
      force_q <= force_d;
      post_q  <= post_d;
      hlth_q  <= hlth_d;
      pos_q   <= pos_d;
      load_q  <= load_d;
      ka_q    <= ka_d;
      poll_q  <= poll_d;
    end
  end

endmodule
`default_nettype wire

[rtl/gripper_command_sequencer_unit.sv]
`default_nettype none
// path: an event is held in the input stage, then its results in the output buffer
// throughput: one event per cycle while the buffer has room for two results
// the rate is set by the decode stage and the four-entry output buffer
// reset: asynchronous, active low; clears the gripper state, the configuration
// registers to their defaults and empties the input stage and output buffer
// ----------------------------------------------------------------------------
// gripper_command_sequencer_unit
// Top level: configuration registers, input stage, decode core and output
// buffer of the gripper command sequencer.
// ----------------------------------------------------------------------------
module gripper_command_sequencer_unit import gcs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  gcs_stream_if.sink       item_in,
  gcs_stream_if.source     result_out
);

  cfg_t                cfg_q;
  logic                stg_valid_q;
  item_t               stg_item_q;
  logic                fire;
  result_t             res0;
  result_t             res1;
  logic                two;
  result_t             obuf_q [OBUF_DEPTH];
  logic [OBUF_AW-1:0]  wr_ptr_q;
  logic [OBUF_AW-1:0]  rd_ptr_q;
  logic [OBUF_AW:0]    cnt_q;
  logic [OBUF_AW:0]    cnt_d;
  logic [OBUF_AW:0]    push_n;
  logic                pop;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_position      <= RST_OPEN_POSITION;
      cfg_q.closed_position    <= RST_CLOSED_POSITION;
      cfg_q.torque_low         <= RST_TORQUE_LOW;
      cfg_q.torque_high        <= RST_TORQUE_HIGH;
      cfg_q.servo_speed        <= RST_SERVO_SPEED;
      cfg_q.keepalive_limit_ms <= RST_KEEPALIVE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPEN_POSITION:   cfg_q.open_position      <= cfg_data_i[11:0];
        CFG_CLOSED_POSITION: cfg_q.closed_position    <= cfg_data_i[11:0];
        CFG_TORQUE_LOW:      cfg_q.torque_low         <= cfg_data_i[9:0];
        CFG_TORQUE_HIGH:     cfg_q.torque_high        <= cfg_data_i[9:0];
        CFG_SERVO_SPEED:     cfg_q.servo_speed        <= cfg_data_i[15:0];
        CFG_KEEPALIVE_LIMIT: cfg_q.keepalive_limit_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage moves on when the buffer has room for two results
  assign fire          = stg_valid_q && (cnt_q <= (OBUF_AW + 1)'(OBUF_DEPTH - 2));
  assign item_in.ready = !stg_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (item_in.ready) begin
      stg_valid_q <= item_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      stg_item_q <= item_in.payload;
    end
  end

  gcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stg_item_q),
    .cfg_i  (cfg_q),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (two)
  );

  // output buffer
  assign pop    = result_out.valid && result_out.ready;
  assign push_n = fire ? (two ? (OBUF_AW + 1)'(2) : (OBUF_AW + 1)'(1)) : '0;
  assign cnt_d  = cnt_q + push_n - {{OBUF_AW{1'b0}}, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[OBUF_AW-1:0];
      rd_ptr_q <= rd_ptr_q + {{(OBUF_AW-1){1'b0}}, pop};
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obuf_q[wr_ptr_q] <= res0;
      if (two) begin
        obuf_q[wr_ptr_q + OBUF_AW'(1)] <= res1;
      end
    end
  end

  assign result_out.valid   = (cnt_q != '0);
  assign result_out.payload = obuf_q[rd_ptr_q];

`ifndef SYNTH
  // buffer never overflows
  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (OBUF_AW + 1)'(OBUF_DEPTH))
    else $error("output buffer count out of range");

  // a two-result event is a hold followed by the open move
  a_two_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && two |-> res0.command_kind == CMD_HOLD && res1.command_kind == CMD_MOVE
                    && !res0.last)
    else $error("bad two-result sequence");

  // the estop latch never clears once reported
  a_estop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && $past(fire) && $past(res0.estop_latched) |-> res0.estop_latched)
    else $error("estop latch cleared");

  // an accepted event reaches the core the next cycle
  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_in.valid && item_in.ready |=> stg_valid_q)
    else $error("accepted event lost in input stage");
`endif

endmodule
`default_nettype wire
